>>> design/cph_pkg.sv
`default_nettype none

package cph_pkg;

    localparam int COORD_WIDTH = 16;
    localparam int KIND_WIDTH  = 2;
    localparam int SIZE_WIDTH  = COORD_WIDTH - 1;
    // Doubled center, so that half sizes stay integers.
    localparam int X2_WIDTH    = COORD_WIDTH + 1;
    // Doubled center plus or minus a full size.
    localparam int EDGE_WIDTH  = COORD_WIDTH + 2;
    // Edge minus radius, or center minus edge.
    localparam int DIFF_WIDTH  = COORD_WIDTH + 3;
    // Sum of two sizes.
    localparam int RAD_WIDTH   = COORD_WIDTH;
    localparam int SQ_WIDTH    = 2 * DIFF_WIDTH;
    localparam int R2_WIDTH    = 2 * RAD_WIDTH;

    typedef enum logic [KIND_WIDTH-1:0] {
        KIND_CIRCLE = 2'd0,
        KIND_RECT   = 2'd1,
        KIND_NONE   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_RECT_RECT,
        MODE_CIRCLE_RECT
    } t_mode;

    typedef struct packed {
        logic [KIND_WIDTH-1:0]         kind;
        logic signed [COORD_WIDTH-1:0] x;
        logic signed [COORD_WIDTH-1:0] y;
        logic [SIZE_WIDTH-1:0]         w;
        logic [SIZE_WIDTH-1:0]         h;
    } t_collider;

    // Probe point, grow amounts and the bounds of the box it is tested against.
    typedef struct packed {
        logic                         valid;
        t_mode                        mode;
        logic signed [X2_WIDTH-1:0]   cx;
        logic signed [X2_WIDTH-1:0]   cy;
        logic [RAD_WIDTH-1:0]         rx;
        logic [RAD_WIDTH-1:0]         ry;
        logic signed [EDGE_WIDTH-1:0] ql;
        logic signed [EDGE_WIDTH-1:0] qr;
        logic signed [EDGE_WIDTH-1:0] qt;
        logic signed [EDGE_WIDTH-1:0] qb;
    } t_s1;

    typedef struct packed {
        logic                         valid;
        t_mode                        mode;
        logic                         band;
        logic                         grown;
        logic signed [DIFF_WIDTH-1:0] dxl;
        logic signed [DIFF_WIDTH-1:0] dxr;
        logic signed [DIFF_WIDTH-1:0] dyt;
        logic signed [DIFF_WIDTH-1:0] dyb;
        logic [RAD_WIDTH-1:0]         r;
    } t_s2;

    typedef struct packed {
        logic                  valid;
        t_mode                 mode;
        logic                  band;
        logic                  grown;
        logic [SQ_WIDTH-1:0]   sq_xl;
        logic [SQ_WIDTH-1:0]   sq_xr;
        logic [SQ_WIDTH-1:0]   sq_yt;
        logic [SQ_WIDTH-1:0]   sq_yb;
        logic [R2_WIDTH-1:0]   r2;
    } t_s3;

endpackage

`default_nettype wire

>>> design/cph_select.sv
`default_nettype none

module cph_select import cph_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_valid,
    input  wire t_collider i_col_a,
    input  wire t_collider i_col_b,
    output t_s1            o_s1
);

    t_s1 r_s1;
    t_s1 n_s1;

    // Every pairing becomes one probe point tested against one box. Two circles
    // test the first center against a zero-size box at the second center with
    // the radius sum; two rectangles grow the second box by the first one's
    // half extents.
    always_comb begin
        logic                         a_circ, a_rect, b_circ, b_rect;
        t_collider                    c_src, q_src;
        logic [SIZE_WIDTH-1:0]        q_w, q_h;
        logic signed [EDGE_WIDTH-1:0] qx2, qy2, qwe, qhe;

        a_circ = (i_col_a.kind == KIND_CIRCLE);
        a_rect = (i_col_a.kind == KIND_RECT);
        b_circ = (i_col_b.kind == KIND_CIRCLE);
        b_rect = (i_col_b.kind == KIND_RECT);

        n_s1       = '0;
        n_s1.valid = i_valid;
        n_s1.mode  = MODE_NONE;
        c_src      = i_col_a;
        q_src      = i_col_b;
        q_w        = i_col_b.w;
        q_h        = i_col_b.h;
        n_s1.rx    = RAD_WIDTH'(i_col_a.w);
        n_s1.ry    = RAD_WIDTH'(i_col_a.h);

        if (a_rect && b_rect) begin
            n_s1.mode = MODE_RECT_RECT;
        end else if (a_circ && b_circ) begin
            n_s1.mode = MODE_CIRCLE_RECT;
            n_s1.rx   = RAD_WIDTH'(i_col_a.w) + RAD_WIDTH'(i_col_b.w);
            n_s1.ry   = n_s1.rx;
            q_w       = '0;
            q_h       = '0;
        end else if (a_circ && b_rect) begin
            n_s1.mode = MODE_CIRCLE_RECT;
            n_s1.ry   = n_s1.rx;
        end else if (a_rect && b_circ) begin
            n_s1.mode = MODE_CIRCLE_RECT;
            c_src     = i_col_b;
            q_src     = i_col_a;
            q_w       = i_col_a.w;
            q_h       = i_col_a.h;
            n_s1.rx   = RAD_WIDTH'(i_col_b.w);
            n_s1.ry   = n_s1.rx;
        end

        n_s1.cx = $signed({c_src.x, 1'b0});
        n_s1.cy = $signed({c_src.y, 1'b0});
        qx2     = EDGE_WIDTH'($signed({q_src.x, 1'b0}));
        qy2     = EDGE_WIDTH'($signed({q_src.y, 1'b0}));
        qwe     = EDGE_WIDTH'($signed({1'b0, q_w}));
        qhe     = EDGE_WIDTH'($signed({1'b0, q_h}));
        n_s1.ql = qx2 - qwe;
        n_s1.qr = qx2 + qwe;
        n_s1.qt = qy2 - qhe;
        n_s1.qb = qy2 + qhe;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1.valid <= 1'b0;
        end else begin
            r_s1 <= n_s1;
        end
    end

    assign o_s1 = r_s1;

endmodule

`default_nettype wire

>>> design/cph_square.sv
`default_nettype none

module cph_square import cph_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_s1  i_s1,
    output t_s3       o_s3
);

    t_s2 r_s2;
    t_s2 n_s2;
    t_s3 r_s3;
    t_s3 n_s3;

    always_comb begin
        logic signed [DIFF_WIDTH-1:0] cx, cy, ql, qr, qt, qb, rx, ry;

        cx = DIFF_WIDTH'(i_s1.cx);
        cy = DIFF_WIDTH'(i_s1.cy);
        ql = DIFF_WIDTH'(i_s1.ql);
        qr = DIFF_WIDTH'(i_s1.qr);
        qt = DIFF_WIDTH'(i_s1.qt);
        qb = DIFF_WIDTH'(i_s1.qb);
        rx = DIFF_WIDTH'($signed({1'b0, i_s1.rx}));
        ry = DIFF_WIDTH'($signed({1'b0, i_s1.ry}));

        n_s2.valid = i_s1.valid;
        n_s2.mode  = i_s1.mode;
        n_s2.band  = (cx >= ql && cx <= qr) || (cy >= qt && cy <= qb);
        n_s2.grown = (cx > ql - rx) && (cx < qr + rx) && (cy > qt - ry) && (cy < qb + ry);
        n_s2.dxl   = cx - ql;
        n_s2.dxr   = cx - qr;
        n_s2.dyt   = cy - qt;
        n_s2.dyb   = cy - qb;
        n_s2.r     = i_s1.rx;
    end

    always_comb begin
        logic signed [SQ_WIDTH-1:0] p_xl, p_xr, p_yt, p_yb;

        p_xl = r_s2.dxl * r_s2.dxl;
        p_xr = r_s2.dxr * r_s2.dxr;
        p_yt = r_s2.dyt * r_s2.dyt;
        p_yb = r_s2.dyb * r_s2.dyb;

        n_s3.valid = r_s2.valid;
        n_s3.mode  = r_s2.mode;
        n_s3.band  = r_s2.band;
        n_s3.grown = r_s2.grown;
        n_s3.sq_xl = $unsigned(p_xl);
        n_s3.sq_xr = $unsigned(p_xr);
        n_s3.sq_yt = $unsigned(p_yt);
        n_s3.sq_yb = $unsigned(p_yb);
        n_s3.r2    = R2_WIDTH'(r_s2.r) * R2_WIDTH'(r_s2.r);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2.valid <= 1'b0;
            r_s3.valid <= 1'b0;
        end else begin
            r_s2 <= n_s2;
            r_s3 <= n_s3;
        end
    end

    assign o_s3 = r_s3;

endmodule

`default_nettype wire

>>> design/cph_decide.sv
`default_nettype none

module cph_decide import cph_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire t_s3  i_s3,
    output logic      o_hit,
    output logic      o_hit_valid
);

    logic r_hit;
    logic r_hit_valid;
    logic n_hit;

    always_comb begin
        logic [SQ_WIDTH:0] s_lt, s_lb, s_rt, s_rb, r2;
        logic              corner;

        s_lt   = {1'b0, i_s3.sq_xl} + {1'b0, i_s3.sq_yt};
        s_lb   = {1'b0, i_s3.sq_xl} + {1'b0, i_s3.sq_yb};
        s_rt   = {1'b0, i_s3.sq_xr} + {1'b0, i_s3.sq_yt};
        s_rb   = {1'b0, i_s3.sq_xr} + {1'b0, i_s3.sq_yb};
        r2     = (SQ_WIDTH + 1)'(i_s3.r2);
        corner = (s_lt < r2) || (s_lb < r2) || (s_rt < r2) || (s_rb < r2);

        // A center off both bands of the box can only reach it at a corner.
        case (i_s3.mode)
            MODE_RECT_RECT:   n_hit = i_s3.grown;
            MODE_CIRCLE_RECT: n_hit = i_s3.band ? i_s3.grown : corner;
            default:          n_hit = 1'b0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit       <= 1'b0;
            r_hit_valid <= 1'b0;
        end else begin
            r_hit       <= i_s3.valid & n_hit;
            r_hit_valid <= i_s3.valid;
        end
    end

    assign o_hit       = r_hit;
    assign o_hit_valid = r_hit_valid;

endmodule

`default_nettype wire

>>> design/collider_pair_hit_test_unit.sv
`default_nettype none

// Pair hit test for circle and rectangle colliders. A beat is taken at every
// clock edge where start is high; busy is always low, so a new pair can enter
// in every cycle. The hit bit for a pair appears on o_hit with o_hit_valid,
// for one cycle only and in the order the pairs went in, once its start beat
// has passed the four register stages: pairing and box bounds, band and edge
// differences, squares of the corner distances, and the final compare. The
// receiver cannot stall the results.

module collider_pair_hit_test_unit import cph_pkg::*; (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [KIND_WIDTH-1:0]         i_type_a,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_ax,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_ay,
    input  wire logic [SIZE_WIDTH-1:0]         i_size_ax,
    input  wire logic [SIZE_WIDTH-1:0]         i_size_ay,
    input  wire logic [KIND_WIDTH-1:0]         i_type_b,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_bx,
    input  wire logic signed [COORD_WIDTH-1:0] i_center_by,
    input  wire logic [SIZE_WIDTH-1:0]         i_size_bx,
    input  wire logic [SIZE_WIDTH-1:0]         i_size_by,
    output logic                               o_hit,
    output logic                               o_hit_valid
);

    t_collider col_a;
    t_collider col_b;
    t_s1       s1;
    t_s3       s3;

    assign busy = 1'b0;

    assign col_a = '{kind: i_type_a, x: i_center_ax, y: i_center_ay,
                     w: i_size_ax, h: i_size_ay};
    assign col_b = '{kind: i_type_b, x: i_center_bx, y: i_center_by,
                     w: i_size_bx, h: i_size_by};

    cph_select u_select (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (start),
        .i_col_a (col_a),
        .i_col_b (col_b),
        .o_s1    (s1)
    );

    cph_square u_square (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_s1    (s1),
        .o_s3    (s3)
    );

    cph_decide u_decide (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s3        (s3),
        .o_hit       (o_hit),
        .o_hit_valid (o_hit_valid)
    );

    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit_valid |-> $past(start, 4))
        else $error("result beat without a start beat four cycles earlier");

    a_hit_needs_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_hit |-> o_hit_valid)
        else $error("hit raised outside a result beat");

    a_none_a: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && $past(i_type_a, 4) != KIND_CIRCLE
                     && $past(i_type_a, 4) != KIND_RECT) |-> !o_hit)
        else $error("hit reported for an empty first collider");

    a_none_b: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_hit_valid && $past(i_type_b, 4) != KIND_CIRCLE
                     && $past(i_type_b, 4) != KIND_RECT) |-> !o_hit)
        else $error("hit reported for an empty second collider");

endmodule

`default_nettype wire

>>> bench/tb.sv
`default_nettype none

module tb;
    import cph_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 5;
    localparam int RANDOM_PAIRS = 528;
    localparam int IDLE_LIMIT   = 1000;
    localparam int DRAIN_CYCLES = 8;
    // Kind code 3 has no enum member; the block treats it like none.
    localparam logic [KIND_WIDTH-1:0] KIND_UNUSED = 2'd3;

    typedef struct {
        t_collider   a;
        t_collider   b;
        int unsigned gap;
    } t_pair_beat;

    typedef struct {
        t_collider a;
        t_collider b;
        bit        hit;
    } t_pending_hit;

    logic      i_clk = 1'b0;
    logic      i_rst_n;
    logic      start = 1'b0;
    logic      busy;
    t_collider drv_a = '0;
    t_collider drv_b = '0;
    logic      o_hit;
    logic      o_hit_valid;

    t_pair_beat   pair_queue[$];
    t_pending_hit hits_due[$];

    bit          taken = 1'b0;
    int unsigned gap_count;
    int unsigned gap_max;
    int          idle_cycles;
    int          errors;
    int          pairs_total;
    int          pairs_in;
    int          pairs_cc;
    int          pairs_rr;
    int          pairs_cr;
    int          pairs_none;
    int          hits_seen;
    int          misses_seen;

    collider_pair_hit_test_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_type_a    (drv_a.kind),
        .i_center_ax (drv_a.x),
        .i_center_ay (drv_a.y),
        .i_size_ax   (drv_a.w),
        .i_size_ay   (drv_a.h),
        .i_type_b    (drv_b.kind),
        .i_center_bx (drv_b.x),
        .i_center_by (drv_b.y),
        .i_size_bx   (drv_b.w),
        .i_size_by   (drv_b.h),
        .o_hit       (o_hit),
        .o_hit_valid (o_hit_valid)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    // All geometry works on doubled centers, so a full size is a doubled half size.
    function automatic bit within_radius(longint px, longint py, longint qx, longint qy,
                                         longint r);
        longint dx;
        longint dy;
        dx = px - qx;
        dy = py - qy;
        return dx * dx + dy * dy < r * r;
    endfunction

    function automatic bit circle_box_hit(t_collider c, t_collider q);
        longint r, cx, cy, lft, rgt, top, bot;
        r   = longint'(c.w);
        cx  = 2 * longint'($signed(c.x));
        cy  = 2 * longint'($signed(c.y));
        lft = 2 * longint'($signed(q.x)) - longint'(q.w);
        rgt = 2 * longint'($signed(q.x)) + longint'(q.w);
        top = 2 * longint'($signed(q.y)) - longint'(q.h);
        bot = 2 * longint'($signed(q.y)) + longint'(q.h);
        // Inside one of the bands the grown box decides; outside both only corners can.
        if ((lft <= cx && cx <= rgt) || (top <= cy && cy <= bot))
            return (lft - r) < cx && cx < (rgt + r) && (top - r) < cy && cy < (bot + r);
        return within_radius(cx, cy, lft, top, r) || within_radius(cx, cy, lft, bot, r) ||
               within_radius(cx, cy, rgt, top, r) || within_radius(cx, cy, rgt, bot, r);
    endfunction

    function automatic bit predict_hit(t_collider a, t_collider b);
        longint ax, ay, bx, by;
        ax = 2 * longint'($signed(a.x));
        ay = 2 * longint'($signed(a.y));
        bx = 2 * longint'($signed(b.x));
        by = 2 * longint'($signed(b.y));
        if (a.kind == KIND_CIRCLE && b.kind == KIND_CIRCLE)
            return within_radius(ax, ay, bx, by, longint'(a.w) + longint'(b.w));
        if (a.kind == KIND_RECT && b.kind == KIND_RECT)
            return (ax - longint'(a.w)) < (bx + longint'(b.w)) &&
                   (ay - longint'(a.h)) < (by + longint'(b.h)) &&
                   (bx - longint'(b.w)) < (ax + longint'(a.w)) &&
                   (by - longint'(b.h)) < (ay + longint'(a.h));
        if (a.kind == KIND_CIRCLE && b.kind == KIND_RECT)
            return circle_box_hit(a, b);
        if (a.kind == KIND_RECT && b.kind == KIND_CIRCLE)
            return circle_box_hit(b, a);
        return 1'b0;
    endfunction

    task automatic queue_pair(int ka, int ax, int ay, int aw, int ah,
                              int kb, int bx, int by, int bw, int bh);
        t_pair_beat p;
        p.a.kind = ka[KIND_WIDTH-1:0];
        p.a.x    = ax[COORD_WIDTH-1:0];
        p.a.y    = ay[COORD_WIDTH-1:0];
        p.a.w    = aw[SIZE_WIDTH-1:0];
        p.a.h    = ah[SIZE_WIDTH-1:0];
        p.b.kind = kb[KIND_WIDTH-1:0];
        p.b.x    = bx[COORD_WIDTH-1:0];
        p.b.y    = by[COORD_WIDTH-1:0];
        p.b.w    = bw[SIZE_WIDTH-1:0];
        p.b.h    = bh[SIZE_WIDTH-1:0];
        p.gap    = $urandom_range(0, gap_max);
        pair_queue.push_back(p);
    endtask

    // Driver: a beat stays on the ports until the edge that takes it.
    always @(negedge i_clk) begin
        t_pair_beat p;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else if (!start || taken) begin
            if (pair_queue.size() == 0) begin
                start <= 1'b0;
            end else if (gap_count < pair_queue[0].gap) begin
                start <= 1'b0;
                gap_count++;
            end else begin
                p = pair_queue.pop_front();
                drv_a <= p.a;
                drv_b <= p.b;
                start <= 1'b1;
                gap_count = 0;
            end
        end
    end

    always @(posedge i_clk) begin
        t_pending_hit rec;
        bit           beat;
        beat = i_rst_n && start && !busy;
        taken <= beat;
        if (beat) begin
            rec.a   = drv_a;
            rec.b   = drv_b;
            rec.hit = predict_hit(drv_a, drv_b);
            hits_due.push_back(rec);
            pairs_in++;
            if (drv_a.kind == KIND_CIRCLE && drv_b.kind == KIND_CIRCLE)
                pairs_cc++;
            else if (drv_a.kind == KIND_RECT && drv_b.kind == KIND_RECT)
                pairs_rr++;
            else if ((drv_a.kind == KIND_CIRCLE && drv_b.kind == KIND_RECT) ||
                     (drv_a.kind == KIND_RECT && drv_b.kind == KIND_CIRCLE))
                pairs_cr++;
            else
                pairs_none++;
        end
        if (i_rst_n && o_hit_valid) begin
            if (hits_due.size() == 0) begin
                $display("%0t: hit result with no pair pending, expected none, got %0b",
                         $realtime, o_hit);
                errors++;
            end else begin
                rec = hits_due.pop_front();
                if (o_hit !== rec.hit) begin
                    $display("%0t: hit mismatch, expected %0b, got %0b", $realtime,
                             rec.hit, o_hit);
                    $display("    a: kind %0d at (%0d,%0d) size %0dx%0d", rec.a.kind,
                             $signed(rec.a.x), $signed(rec.a.y), rec.a.w, rec.a.h);
                    $display("    b: kind %0d at (%0d,%0d) size %0dx%0d", rec.b.kind,
                             $signed(rec.b.x), $signed(rec.b.y), rec.b.w, rec.b.h);
                    errors++;
                end
                if (o_hit === 1'b1)
                    hits_seen++;
                else
                    misses_seen++;
            end
        end
        idle_cycles = (beat || o_hit_valid) ? 0 : idle_cycles + 1;
    end

    initial begin
        while (idle_cycles < IDLE_LIMIT) @(negedge i_clk);
        $display("%0t: nothing moved for %0d cycles", $realtime, IDLE_LIMIT);
        $display("collider_pair_hit_test_unit test failed");
        $finish;
    end

    initial begin
        int n, pick, lim, ka, kb, ax, ay, aw, ah, bw, bh, ext_a, ext_b;
        int reach_x, reach_y, dx, dy;
        i_rst_n = 1'b0;
        gap_max = 3;

        // Circles touching exactly, then just overlapping, then two zero radii.
        queue_pair(KIND_CIRCLE, 0, 0, 32, 0, KIND_CIRCLE, 32, 0, 32, 0);
        queue_pair(KIND_CIRCLE, 0, 0, 32, 0, KIND_CIRCLE, 31, 0, 32, 0);
        queue_pair(KIND_CIRCLE, 7, -7, 0, 0, KIND_CIRCLE, 7, -7, 0, 0);
        // Rectangles sharing an edge, overlapping, and of zero size.
        queue_pair(KIND_RECT, 0, 0, 32, 32, KIND_RECT, 32, 0, 32, 32);
        queue_pair(KIND_RECT, 0, 0, 32, 32, KIND_RECT, 31, 31, 32, 32);
        queue_pair(KIND_RECT, 3, 3, 0, 0, KIND_RECT, 3, 3, 0, 0);
        // Circle in the y band, inside and then touching the grown box.
        queue_pair(KIND_CIRCLE, 0, 40, 20, 0, KIND_RECT, 0, 0, 64, 64);
        queue_pair(KIND_CIRCLE, 0, 42, 20, 0, KIND_RECT, 0, 0, 64, 64);
        // Corner region: hit, near miss, exact radius, and the swapped order.
        queue_pair(KIND_CIRCLE, 38, 38, 20, 0, KIND_RECT, 0, 0, 64, 64);
        queue_pair(KIND_CIRCLE, 40, 40, 20, 0, KIND_RECT, 0, 0, 64, 64);
        queue_pair(KIND_CIRCLE, 6, 8, 10, 0, KIND_RECT, 0, 0, 6, 8);
        queue_pair(KIND_RECT, 0, 0, 64, 64, KIND_CIRCLE, -38, -38, 20, 0);
        // Zero radius circle inside a box and on its edge.
        queue_pair(KIND_CIRCLE, 0, 0, 0, 0, KIND_RECT, 0, 0, 10, 10);
        queue_pair(KIND_RECT, 0, 0, 10, 10, KIND_CIRCLE, 5, 0, 0, 0);
        // Pairings with none or the unused code never hit.
        queue_pair(KIND_NONE, 0, 0, 100, 100, KIND_CIRCLE, 0, 0, 100, 100);
        queue_pair(KIND_CIRCLE, 0, 0, 100, 100, KIND_NONE, 0, 0, 100, 100);
        queue_pair(KIND_UNUSED, 0, 0, 100, 100, KIND_RECT, 0, 0, 100, 100);
        queue_pair(KIND_RECT, 0, 0, 100, 100, KIND_UNUSED, 0, 0, 100, 100);
        // Field extremes.
        queue_pair(KIND_CIRCLE, -32768, -32768, 32767, 32767,
                   KIND_CIRCLE, 32767, 32767, 32767, 32767);
        queue_pair(KIND_RECT, -32768, 0, 32767, 32767, KIND_RECT, 32767, 0, 32767, 32767);
        queue_pair(KIND_CIRCLE, 32767, -32768, 32767, 0, KIND_RECT, 32767, -32768, 0, 0);
        queue_pair(KIND_RECT, -1, -1, 32767, 32767, KIND_RECT, 0, 0, 0, 0);
        queue_pair(KIND_RECT, -32768, 32767, 32767, 32767,
                   KIND_CIRCLE, -32768, 32767, 32767, 32767);

        // Mostly near-contact pairs so both outcomes stay common; some pure noise.
        for (n = 0; n < RANDOM_PAIRS; n++) begin
            gap_max = ((n / 100) % 2 == 0) ? 3 : 0;
            if ($urandom_range(0, 4) == 0) begin
                queue_pair($urandom_range(0, 3), $urandom(), $urandom(), $urandom(),
                           $urandom(), $urandom_range(0, 3), $urandom(), $urandom(),
                           $urandom(), $urandom());
            end else begin
                ka = $urandom_range(int'(KIND_CIRCLE), int'(KIND_RECT));
                kb = $urandom_range(int'(KIND_CIRCLE), int'(KIND_RECT));
                if ($urandom_range(0, 9) == 0)
                    ka = $urandom_range(int'(KIND_NONE), int'(KIND_UNUSED));
                if ($urandom_range(0, 9) == 0)
                    kb = $urandom_range(int'(KIND_NONE), int'(KIND_UNUSED));
                pick = $urandom_range(0, 9);
                lim  = (pick < 6) ? 63 : ((pick < 9) ? 2047 : 32767);
                aw   = $urandom_range(0, lim);
                ah   = $urandom_range(0, lim);
                bw   = $urandom_range(0, lim);
                bh   = $urandom_range(0, lim);
                ax   = $urandom_range(0, 65535);
                ay   = $urandom_range(0, 65535);
                ax  -= 32768;
                ay  -= 32768;
                // A circle reaches as far in y as in x.
                ext_a   = (ka == KIND_CIRCLE) ? aw : ah;
                ext_b   = (kb == KIND_CIRCLE) ? bw : bh;
                reach_x = (aw + bw) / 2 + 2;
                reach_y = (ext_a + ext_b) / 2 + 2;
                dx = $urandom_range(0, 2 * reach_x);
                dy = $urandom_range(0, 2 * reach_y);
                dx -= reach_x;
                dy -= reach_y;
                if ($urandom_range(0, 7) == 0) begin
                    dx = ($urandom_range(0, 1) == 1) ? (aw + bw) / 2 : -((aw + bw) / 2);
                    dy = 0;
                end
                queue_pair(ka, ax, ay, aw, ah, kb, ax + dx, ay + dy, bw, bh);
            end
        end
        pairs_total = pair_queue.size();

        repeat (2) @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (pairs_in < pairs_total || hits_due.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("Checked %0d pairs: %0d circle/circle, %0d rect/rect, %0d circle/rect, "
                 , pairs_in, pairs_cc, pairs_rr, pairs_cr);
        $display("%0d with none or unused kinds; %0d hits and %0d misses seen, %0d errors",
                 pairs_none, hits_seen, misses_seen, errors);
        if (errors == 0) begin
            $display("collider_pair_hit_test_unit test passed");
        end else begin
            $display("collider_pair_hit_test_unit test failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
